// File: hw/rtl/dcfft_pkg.sv
// Shared types and constants for the DC-removed radix-2 FFT block.
package dcfft_pkg;

    localparam int POINTS_DEF      = 2048;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int SAMPLE_W   = 16;
    localparam int BIN_BITS   = 28;
    localparam int INDEX_BITS = 11;
    // Widest frame position the command word has to carry (8192 points).
    localparam int POS_BITS   = 13;

    localparam longint BIN_MAX = 64'sd134217727;
    localparam longint BIN_MIN = -64'sd134217728;

    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_real;
        logic signed [SAMPLE_W-1:0] sample_imag;
    } t_sample;

    typedef struct packed {
        logic signed [BIN_BITS-1:0] bin_real;
        logic signed [BIN_BITS-1:0] bin_imag;
        logic [INDEX_BITS-1:0]      bin_index;
        logic                       frame_last;
    } t_bin;

    // One classified input word as handed from the front end to the engine.
    typedef struct packed {
        t_sample             smp;
        logic [POS_BITS-1:0] pos;
        logic                last;
        logic                produce;
    } t_cmd;

endpackage

// File: hw/rtl/dcfft_fifo.sv
// Small synchronous FIFO built from registers, used for the command and result queues.
module dcfft_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PB = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PB:0]      r_wr;
    logic [PB:0]      r_rd;
    logic [PB:0]      n_wr;
    logic [PB:0]      n_rd;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[PB] != r_rd[PB]) && (r_wr[PB-1:0] == r_rd[PB-1:0]);
    assign o_data  = r_mem[r_rd[PB-1:0]];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr = do_push ? r_wr + 1'b1 : r_wr;
        n_rd = do_pop ? r_rd + 1'b1 : r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr[PB-1:0]] <= i_data;
        end
    end

endmodule

// File: hw/rtl/dcfft_front.sv
// Front end: takes sample words, tracks the frame position and tags each word.
module dcfft_front #(
    parameter int POINTS = dcfft_pkg::POINTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dcfft_pkg::t_sample i_sample,
    output logic              o_full,
    input  logic              i_cmd_full,
    output logic              o_cmd_push,
    output dcfft_pkg::t_cmd   o_cmd
);
    import dcfft_pkg::*;

    localparam int LOG2 = $clog2(POINTS);

    logic [LOG2-1:0] r_pos;
    logic [LOG2-1:0] n_pos;
    logic            r_primed;
    logic            n_primed;
    logic            is_last;

    assign is_last    = (r_pos == LOG2'(POINTS - 1));
    assign o_full     = i_cmd_full;
    assign o_cmd_push = i_push && !i_cmd_full;

    always_comb begin
        o_cmd.smp     = i_sample;
        o_cmd.pos     = POS_BITS'(r_pos);
        o_cmd.last    = is_last;
        // A result exists once one whole frame has gone through the engine.
        o_cmd.produce = r_primed;
        n_pos         = r_pos;
        n_primed      = r_primed;
        if (o_cmd_push) begin
            n_pos = r_pos + 1'b1;
            if (is_last) begin
                n_primed = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_primed <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_primed <= n_primed;
        end
    end

endmodule

// File: hw/rtl/dcfft_back.sv
// Back end: sample store, result read-out and the in-place butterfly engine.
module dcfft_back #(
    parameter int POINTS      = dcfft_pkg::POINTS_DEF,
    parameter int SAMPLE_BITS = dcfft_pkg::SAMPLE_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_empty,
    input  dcfft_pkg::t_cmd i_cmd,
    output logic            o_cmd_pop,
    input  logic            i_res_full,
    output logic            o_res_push,
    output dcfft_pkg::t_bin o_res
);
    import dcfft_pkg::*;

    localparam int LOG2    = $clog2(POINTS);
    localparam int HB      = LOG2 - 1;
    localparam int HALF    = POINTS / 2;
    localparam int QTR     = POINTS / 4;
    localparam int STG     = $clog2(LOG2);
    localparam int W       = SAMPLE_BITS + LOG2 + 3;
    localparam int SW      = SAMPLE_BITS + LOG2;
    localparam int TW_BITS = 18;
    localparam int PW      = W + TW_BITS;
    localparam int AW      = LOG2 + 1;

    localparam logic [63:0] PI_HALF_Q61 = 64'h3243F6A8885A308D;
    localparam logic [63:0] ONE_Q61     = 64'h2000000000000000;
    // Angle step of one table entry in Q61, split into quotient and remainder.
    localparam logic [63:0] TW_STEP_Q   = PI_HALF_Q61 / 64'(QTR);
    localparam logic [63:0] TW_STEP_R   = PI_HALF_Q61 % 64'(QTR);

    typedef logic [2*TW_BITS-1:0] t_tw_rom [HALF];

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_OUT   = 8'b0000_0010,
        S_SETUP = 8'b0000_0100,
        S_RD    = 8'b0000_1000,
        S_LD    = 8'b0001_0000,
        S_MUL   = 8'b0010_0000,
        S_SUM   = 8'b0100_0000,
        S_WC    = 8'b1000_0000
    } t_state;

    function automatic logic [63:0] mul_q61(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[124:61];
    endfunction

    // Unsigned long division by shift and subtract, used only to build the table.
    function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [TW_BITS-1:0] round_q16(logic signed [63:0] v);
        logic [63:0] u;
        u = (v < 0) ? 64'd0 : v;
        u = (u + (64'd1 << 44)) >> 45;
        return u[TW_BITS-1:0];
    endfunction

    // Cosine and sine of a quarter-wave angle from a Q61 Taylor series.
    function automatic logic [2*TW_BITS-1:0] quarter_wave(logic [63:0] k);
        logic [63:0]        theta;
        logic [63:0]        term;
        logic signed [63:0] ca;
        logic signed [63:0] sa;
        theta = TW_STEP_Q * k + ((TW_STEP_R * k) >> (LOG2 - 2));
        term  = ONE_Q61;
        ca    = ONE_Q61;
        sa    = '0;
        for (int n = 1; n < 48; n++) begin
            if (term != 0) begin
                term = div_u64(mul_q61(term, theta), 64'(n));
                if (((n >> 1) & 1) != 0) begin
                    if ((n & 1) != 0) sa = sa - term;
                    else              ca = ca - term;
                end else begin
                    if ((n & 1) != 0) sa = sa + term;
                    else              ca = ca + term;
                end
            end
        end
        return {round_q16(ca), round_q16(sa)};
    endfunction

    function automatic t_tw_rom build_rom();
        t_tw_rom                    rom;
        logic [2*TW_BITS-1:0]       cs;
        logic signed [TW_BITS-1:0]  c;
        logic signed [TW_BITS-1:0]  s;
        for (int k = 0; k < HALF; k++) begin
            if (k <= QTR) begin
                cs = quarter_wave(64'(k));
                c  = cs[2*TW_BITS-1:TW_BITS];
                s  = cs[TW_BITS-1:0];
            end else begin
                cs = quarter_wave(64'(k - QTR));
                c  = -$signed(cs[TW_BITS-1:0]);
                s  = cs[2*TW_BITS-1:TW_BITS];
            end
            rom[k] = {c, -s};
        end
        return rom;
    endfunction

    localparam t_tw_rom TW_ROM = build_rom();

    function automatic logic [BIN_BITS-1:0] sat_bin(logic signed [W-1:0] v);
        logic signed [W+BIN_BITS-1:0] x;
        x = (W+BIN_BITS)'(v);
        if (x > (W+BIN_BITS)'(BIN_MAX)) return BIN_BITS'(BIN_MAX);
        if (x < (W+BIN_BITS)'(BIN_MIN)) return BIN_BITS'(BIN_MIN);
        return BIN_BITS'(x);
    endfunction

    // Control state
    t_state                  r_state;
    t_state                  n_state;
    logic                    r_bank;
    logic                    n_bank;
    logic signed [SW-1:0]    r_sum_re;
    logic signed [SW-1:0]    n_sum_re;
    logic signed [SW-1:0]    r_sum_im;
    logic signed [SW-1:0]    n_sum_im;
    logic [STG-1:0]          r_stage;
    logic [STG-1:0]          n_stage;
    logic [HB-1:0]           r_bfly;
    logic [HB-1:0]           n_bfly;
    logic [LOG2-1:0]         r_pos;
    logic [LOG2-1:0]         n_pos;
    logic                    r_last;
    logic                    n_last;

    // Payload registers
    logic signed [SAMPLE_BITS-1:0] r_mean_re;
    logic signed [SAMPLE_BITS-1:0] r_mean_im;
    logic [2*W-1:0]          r_mem [2*POINTS];
    logic [2*W-1:0]          r_rda;
    logic [2*W-1:0]          r_rdb;
    logic [2*TW_BITS-1:0]    r_tw;
    logic signed [W-1:0]     r_ar;
    logic signed [W-1:0]     r_ai;
    logic signed [W-1:0]     r_cr;
    logic signed [W-1:0]     r_ci;
    logic signed [TW_BITS-1:0] r_wr;
    logic signed [TW_BITS-1:0] r_wi;
    logic signed [PW-1:0]    r_p1;
    logic signed [PW-1:0]    r_p2;
    logic signed [PW-1:0]    r_p3;
    logic signed [PW-1:0]    r_p4;
    logic signed [W-1:0]     r_nc_re;
    logic signed [W-1:0]     r_nc_im;

    // Combinational helpers
    logic signed [SAMPLE_BITS-1:0] smp_re;
    logic signed [SAMPLE_BITS-1:0] smp_im;
    logic [LOG2-1:0]         cmd_pos;
    logic [LOG2-1:0]         rev_pos;
    logic [HB-1:0]           span_mask;
    logic [HB-1:0]           k_idx;
    logic [LOG2-1:0]         a_idx;
    logic [LOG2-1:0]         c_idx;
    logic [HB-1:0]           tw_idx;
    logic signed [W-1:0]     rda_re;
    logic signed [W-1:0]     rda_im;
    logic signed [W-1:0]     rdb_re;
    logic signed [W-1:0]     rdb_im;
    logic signed [W-1:0]     mean_re;
    logic signed [W-1:0]     mean_im;
    logic signed [PW:0]      tsum_re;
    logic signed [PW:0]      tsum_im;
    logic signed [W-1:0]     tr;
    logic signed [W-1:0]     ti;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [2*W-1:0]          wr_data;
    logic [AW-1:0]           rda_addr;
    logic [AW-1:0]           rdb_addr;

    assign smp_re  = SAMPLE_BITS'($unsigned(i_cmd.smp.sample_real));
    assign smp_im  = SAMPLE_BITS'($unsigned(i_cmd.smp.sample_imag));
    assign cmd_pos = i_cmd.pos[LOG2-1:0];

    // Samples land bit-reversed so the first stage reads natural addresses.
    always_comb begin
        for (int b = 0; b < LOG2; b++) begin
            rev_pos[b] = cmd_pos[LOG2-1-b];
        end
    end

    // Butterfly addressing: a has a zero inserted at bit "stage" of the index.
    assign span_mask = ~({HB{1'b1}} << r_stage);
    assign k_idx     = r_bfly & span_mask;
    assign a_idx     = (LOG2'(r_bfly & ~span_mask) << 1) | LOG2'(k_idx);
    assign c_idx     = a_idx | (LOG2'(1) << r_stage);
    assign tw_idx    = k_idx << (HB - r_stage);

    assign rda_re  = r_rda[2*W-1:W];
    assign rda_im  = r_rda[W-1:0];
    assign rdb_re  = r_rdb[2*W-1:W];
    assign rdb_im  = r_rdb[W-1:0];
    // The frame mean comes off only while the first stage reads the samples.
    assign mean_re = (r_stage == '0) ? W'(r_mean_re) : '0;
    assign mean_im = (r_stage == '0) ? W'(r_mean_im) : '0;

    assign tsum_re = (PW+1)'(r_p1) - (PW+1)'(r_p2) + (PW+1)'(32768);
    assign tsum_im = (PW+1)'(r_p3) + (PW+1)'(r_p4) + (PW+1)'(32768);
    assign tr      = W'(tsum_re >>> 16);
    assign ti      = W'(tsum_im >>> 16);

    always_comb begin
        o_res.bin_real   = sat_bin(rda_re);
        o_res.bin_imag   = sat_bin(rda_im);
        o_res.bin_index  = INDEX_BITS'(r_pos);
        o_res.frame_last = r_last;
    end

    always_comb begin
        n_state    = r_state;
        n_bank     = r_bank;
        n_sum_re   = r_sum_re;
        n_sum_im   = r_sum_im;
        n_stage    = r_stage;
        n_bfly     = r_bfly;
        n_pos      = r_pos;
        n_last     = r_last;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = '0;
        rda_addr   = '0;
        rdb_addr   = '0;
        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    wr_en     = 1'b1;
                    wr_addr   = {r_bank, rev_pos};
                    wr_data   = {W'(smp_re), W'(smp_im)};
                    rda_addr  = {~r_bank, cmd_pos};
                    n_sum_re  = r_sum_re + SW'(smp_re);
                    n_sum_im  = r_sum_im + SW'(smp_im);
                    n_pos     = cmd_pos;
                    n_last    = i_cmd.last;
                    if (i_cmd.produce) begin
                        n_state = S_OUT;
                    end else if (i_cmd.last) begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_OUT: begin
                o_res_push = 1'b1;
                n_state    = r_last ? S_SETUP : S_IDLE;
            end
            S_SETUP: begin
                n_sum_re = '0;
                n_sum_im = '0;
                n_stage  = '0;
                n_bfly   = '0;
                n_state  = S_RD;
            end
            S_RD: begin
                rda_addr = {r_bank, a_idx};
                rdb_addr = {r_bank, c_idx};
                n_state  = S_LD;
            end
            S_LD: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                wr_en   = 1'b1;
                wr_addr = {r_bank, a_idx};
                wr_data = {W'(r_ar + tr), W'(r_ai + ti)};
                n_state = S_WC;
            end
            S_WC: begin
                wr_en   = 1'b1;
                wr_addr = {r_bank, c_idx};
                wr_data = {r_nc_re, r_nc_im};
                n_state = S_RD;
                if (r_bfly == {HB{1'b1}}) begin
                    n_bfly = '0;
                    if (r_stage == STG'(LOG2 - 1)) begin
                        n_bank  = ~r_bank;
                        n_state = S_IDLE;
                    end else begin
                        n_stage = r_stage + 1'b1;
                    end
                end else begin
                    n_bfly = r_bfly + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bank   <= 1'b0;
            r_sum_re <= '0;
            r_sum_im <= '0;
            r_stage  <= '0;
            r_bfly   <= '0;
            r_pos    <= '0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bank   <= n_bank;
            r_sum_re <= n_sum_re;
            r_sum_im <= n_sum_im;
            r_stage  <= n_stage;
            r_bfly   <= n_bfly;
            r_pos    <= n_pos;
            r_last   <= n_last;
        end
    end

    // Sample store with one write port and two registered read ports.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rda <= r_mem[rda_addr];
        r_rdb <= r_mem[rdb_addr];
        r_tw  <= TW_ROM[tw_idx];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SETUP) begin
            r_mean_re <= SAMPLE_BITS'(r_sum_re >>> LOG2);
            r_mean_im <= SAMPLE_BITS'(r_sum_im >>> LOG2);
        end
        if (r_state == S_LD) begin
            r_ar <= rda_re - mean_re;
            r_ai <= rda_im - mean_im;
            r_cr <= rdb_re - mean_re;
            r_ci <= rdb_im - mean_im;
            r_wr <= r_tw[2*TW_BITS-1:TW_BITS];
            r_wi <= r_tw[TW_BITS-1:0];
        end
        if (r_state == S_MUL) begin
            r_p1 <= r_wr * r_cr;
            r_p2 <= r_wi * r_ci;
            r_p3 <= r_wr * r_ci;
            r_p4 <= r_wi * r_cr;
        end
        if (r_state == S_SUM) begin
            r_nc_re <= r_ar - tr;
            r_nc_im <= r_ai - ti;
        end
    end

endmodule

// File: hw/rtl/dc_removed_radix2_fft.sv
// Top level of the DC-removed radix-2 FFT: front end, command queue, engine, result queue.
//
//   Channel   Handshake           Word      Direction
//   --------  ------------------  --------  ---------
//   samples   push / full         i_sample  in
//   bins      pop / empty         o_bin     out
//
// During the first frame the engine takes each sample word, when the result queue
// has room, in its idle state alone; afterwards it also passes through the output
// state, since it reads back the previous frame's bin at the same position. After
// the last word of a frame the butterfly unit runs setup, then for every butterfly
// of every stage the read, load, multiply, first-write and second-write steps. The
// engine has a single butterfly unit and the sample store one write port.
// Reset is synchronous and active low; it clears the frame position, the bank
// select and the running sums. The store itself is not cleared.
// A four-word command queue lets the front end keep taking samples while the
// engine works; full rises once it fills. The two-word result queue lets the
// engine go on while a bin waits for pop.
module dc_removed_radix2_fft #(
    parameter int POINTS      = dcfft_pkg::POINTS_DEF,
    parameter int SAMPLE_BITS = dcfft_pkg::SAMPLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  dcfft_pkg::t_sample i_sample,
    input  logic               pop,
    output logic               empty,
    output dcfft_pkg::t_bin    o_bin
);
    import dcfft_pkg::*;

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_bin);

    logic       cmd_full;
    logic       cmd_push;
    t_cmd       cmd_in;
    logic       cmd_empty;
    logic       cmd_pop;
    logic [CMD_W-1:0] cmd_out;
    logic       res_full;
    logic       res_push;
    t_bin       res_in;
    logic [RES_W-1:0] res_out;

    // The front end numbers each word within its frame and marks whether a
    // bin of the previous frame is due for it.
    dcfft_front #(
        .POINTS (POINTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_sample   (i_sample),
        .o_full     (full),
        .i_cmd_full (cmd_full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    dcfft_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (CMD_W'(cmd_in)),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    // The engine stores samples, returns bins and runs the transform in place
    // once a frame is complete, then swaps the two banks.
    dcfft_back #(
        .POINTS      (POINTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (t_cmd'(cmd_out)),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    dcfft_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (RES_W'(res_in)),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_bin = t_bin'(res_out);

endmodule
